/* src/ucs_pkg.sv */
// ----------------------------------------------------------------------------
// ucs_pkg
// Shared types, constants and the ones' complement adder for the UDP/IP
// checksum stream unit.
// ----------------------------------------------------------------------------
package ucs_pkg;

    localparam logic [15:0] UDP_PROTO_NUMBER = 16'd17;
    localparam logic [15:0] WORD_MASK        = 16'hFFFF;

    // Packet summary handed from the accumulator to the finishing stage.
    typedef struct packed {
        logic        valid;
        logic [15:0] sum;
        logic [15:0] length;
        logic        udp;
    } ucs_pkt_t;

    // Input register status, for checking.
    typedef struct packed {
        logic in_valid;
        logic in_last;
    } ucs_stat_t;

    // 16-bit add with end-around carry.
    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        begin
            s = {1'b0, a} + {1'b0, b};
            oc_add = s[15:0] + {15'd0, s[16]};
        end
    endfunction

endpackage

/* src/ucs_accum.sv */
// ----------------------------------------------------------------------------
// ucs_accum
// Input register and per-packet accumulator: pairs bytes into words, keeps
// the folded sum and the UDP length, presents the packet summary on last.
// ----------------------------------------------------------------------------
module ucs_accum
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // [7:0] data_byte
    input  logic             s_tuser,   // [0] is_address
    input  logic             s_tlast,
    input  logic             udp_mode,
    input  logic             fin_ready,
    output ucs_pkg::ucs_pkt_t pkt,
    output ucs_pkg::ucs_stat_t stat
);

    logic        in_valid_reg;
    logic [7:0]  in_byte_reg;
    logic        in_addr_reg;
    logic        in_last_reg;

    logic [15:0] sum_reg;
    logic [15:0] sum_next;
    logic [7:0]  held_reg;
    logic [7:0]  held_next;
    logic        odd_reg;
    logic        odd_next;
    logic [15:0] len_reg;
    logic [15:0] len_next;

    logic        in_fire;
    logic        s_fire;
    logic [15:0] tail_sum;

    assign in_fire  = in_valid_reg && (!in_last_reg || fin_ready);
    assign s_tready = !in_valid_reg || in_fire;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_byte_reg <= s_tdata;
            in_addr_reg <= s_tuser;
            in_last_reg <= s_tlast;
        end
    end

    always_comb
    begin
        if (odd_reg)
        begin
            sum_next  = ucs_pkg::oc_add(sum_reg, {held_reg, in_byte_reg});
            held_next = held_reg;
            odd_next  = 1'b0;
        end
        else
        begin
            sum_next  = sum_reg;
            held_next = in_byte_reg;
            odd_next  = 1'b1;
        end
        if (udp_mode && !in_addr_reg)
        begin
            len_next = len_reg + 16'd1;
        end
        else
        begin
            len_next = len_reg;
        end
        // odd tail padded with a zero low byte
        if (odd_next)
        begin
            tail_sum = ucs_pkg::oc_add(sum_next, {held_next, 8'h00});
        end
        else
        begin
            tail_sum = sum_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= 16'd0;
            held_reg <= 8'd0;
            odd_reg  <= 1'b0;
            len_reg  <= 16'd0;
        end
        else if (in_fire)
        begin
            if (in_last_reg)
            begin
                sum_reg  <= 16'd0;
                held_reg <= 8'd0;
                odd_reg  <= 1'b0;
                len_reg  <= 16'd0;
            end
            else
            begin
                sum_reg  <= sum_next;
                held_reg <= held_next;
                odd_reg  <= odd_next;
                len_reg  <= len_next;
            end
        end
    end

    assign pkt.valid  = in_valid_reg && in_last_reg;
    assign pkt.sum    = tail_sum;
    assign pkt.length = len_next;
    assign pkt.udp    = udp_mode;

    assign stat.in_valid = in_valid_reg;
    assign stat.in_last  = in_last_reg;

endmodule

/* src/ucs_finish.sv */
// ----------------------------------------------------------------------------
// ucs_finish
// In UDP mode adds the pseudo-header length and protocol; inverts the sum and
// holds the checksum in the output register.
// ----------------------------------------------------------------------------
module ucs_finish
(
    input  logic              clk,
    input  logic              rst_n,
    input  ucs_pkg::ucs_pkt_t pkt,
    output logic              fin_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata    // [15:0] checksum
);

    logic        m_valid_reg;
    logic [15:0] csum_reg;
    logic [15:0] csum_next;
    logic [15:0] s1;
    logic [15:0] s2;
    logic [15:0] inv;
    logic        load;

    assign fin_ready = !m_valid_reg || m_tready;
    assign load      = pkt.valid && fin_ready;

    always_comb
    begin
        if (pkt.udp)
        begin
            s1 = ucs_pkg::oc_add(pkt.sum, pkt.length);
            s2 = ucs_pkg::oc_add(s1, ucs_pkg::UDP_PROTO_NUMBER);
        end
        else
        begin
            s1 = pkt.sum;
            s2 = s1;
        end
        inv = ~s2;
        if (pkt.udp && (inv == 16'd0))
        begin
            csum_next = ucs_pkg::WORD_MASK;
        end
        else
        begin
            csum_next = inv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (fin_ready)
        begin
            m_valid_reg <= pkt.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            csum_reg <= csum_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = csum_reg;

endmodule

/* src/udp_ip_checksum_stream_unit.sv */
// ----------------------------------------------------------------------------
// udp_ip_checksum_stream_unit
// Internet checksum over a byte stream, IPv4 header or UDP with pseudo-header.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel: one byte per beat in s_tdata, s_tuser flags a pseudo-header
//   address byte, s_tlast marks the final byte of a packet.
//   Master channel: one 16-bit checksum per packet in m_tdata.
//   cfg_we/cfg_wdata write the mode (0 = IPv4 header, 1 = UDP); write it
//   only between packets.
//   Throughput: one byte per cycle, sustained while the receiver does not
//   stall; the input register and the accumulator take a byte every cycle,
//   the output register takes a result every cycle while it is not stalled.
//   The checksum is loaded into the output register, and m_tvalid rises,
//   once the last byte sits in the input register and fin_ready is high.
//   Reset clears the mode, the running sum, the length count and all valids.
//   When the receiver stalls, the result is held; bytes keep flowing until a
//   second last byte reaches the input register, which then waits and drops
//   s_tready.
// ----------------------------------------------------------------------------
module udp_ip_checksum_stream_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,   // [0] checksum_mode
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,     // [7:0] data_byte
    input  logic        s_tuser,     // [0] is_address
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // [15:0] checksum
);

    logic               mode_reg;
    logic               fin_ready;
    ucs_pkg::ucs_pkt_t  pkt;
    ucs_pkg::ucs_stat_t stat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_wdata;
        end
    end

    ucs_accum u_accum
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .udp_mode  (mode_reg),
        .fin_ready (fin_ready),
        .pkt       (pkt),
        .stat      (stat)
    );

    ucs_finish u_finish
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .fin_ready (fin_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`ifndef SYNTH
    // a waiting last byte blocks the input while the result is stalled
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.in_valid && stat.in_last && m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted over a stalled last beat");

    // a new result only follows a last byte in the input register
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(stat.in_valid && stat.in_last))
        else $error("result without a last beat");
`endif

endmodule

/* sim/ucs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs_checker
// Watches the byte and checksum channels of the UDP/IP checksum stream unit.
// Keeps its own copy of the running sum, held byte, length count and mode.
// From these it works out the checksum of each packet. Every result beat is
// compared with the oldest checksum still owed.
// ----------------------------------------------------------------------------
module ucs_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    output int          mismatches,
    output int          pending
);

    logic        udp_mode;
    logic [15:0] word_sum;
    logic [7:0]  high_byte;
    logic        have_high;
    logic [15:0] byte_count;
    logic [15:0] owed_checksums[$];
    logic [15:0] want;

    function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] wide;
        wide = {1'b0, a} + {1'b0, b};
        return wide[15:0] + {15'd0, wide[16]};
    endfunction

    task automatic absorb_byte(input logic [7:0] b, input logic addr, input logic fin);
        logic [15:0] total;
        logic [15:0] csum;
        if (have_high)
        begin
            word_sum  = fold_add(word_sum, {high_byte, b});
            have_high = 1'b0;
        end
        else
        begin
            high_byte = b;
            have_high = 1'b1;
        end
        if (udp_mode && !addr)
            byte_count = byte_count + 16'd1;
        if (fin)
        begin
            total = word_sum;
            // odd tail: pad with a zero low byte
            if (have_high)
                total = fold_add(total, {high_byte, 8'h00});
            if (udp_mode)
            begin
                total = fold_add(total, byte_count);
                total = fold_add(total, ucs_pkg::UDP_PROTO_NUMBER);
            end
            csum = ~total;
            if (udp_mode && csum == 16'h0000)
                csum = ucs_pkg::WORD_MASK;
            owed_checksums.push_back(csum);
            word_sum   = '0;
            high_byte  = '0;
            have_high  = 1'b0;
            byte_count = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            udp_mode   = 1'b0;
            word_sum   = '0;
            high_byte  = '0;
            have_high  = 1'b0;
            byte_count = '0;
            owed_checksums.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
                udp_mode = cfg_wdata;
            if (s_tvalid && s_tready)
                absorb_byte(s_tdata, s_tuser, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (owed_checksums.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected checksum beat, expected none, actual %04h",
                             $realtime, m_tdata);
                end
                else
                begin
                    want = owed_checksums.pop_front();
                    if (m_tdata !== want)
                    begin
                        mismatches++;
                        $display("%0t: checksum mismatch, expected %04h, actual %04h",
                                 $realtime, want, m_tdata);
                    end
                end
            end
        end
        pending = owed_checksums.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the UDP/IP checksum stream unit.
// A short directed set covers odd tails, ignored address flags in header mode,
// an odd address count and the zero-to-0xFFFF mapping. Random packets follow
// in both modes, under several idling patterns on either channel. Checking is
// done by ucs_checker.
// ----------------------------------------------------------------------------
module tb_top;

    localparam logic MODE_IPV4_HDR   = 1'b0;
    localparam logic MODE_UDP        = 1'b1;
    localparam int   STALL_LIMIT     = 2000;
    localparam int   DRAIN_CYCLES    = 8;
    localparam int   BYTES_PER_PHASE = 250;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    int src_idle_pct;
    int sink_stall_pct;
    int mismatches;
    int pending;
    int quiet_cycles;
    int sent;
    int n_sent;

    udp_ip_checksum_stream_unit u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    ucs_checker u_checker
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // receiver back-pressure
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    initial
    begin
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("Some tests failed");
        $finish;
    end

    // returns at the edge where the beat is taken
    task automatic drive_beat(input logic [7:0] b, input logic addr, input logic fin);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= addr;
        s_tlast  <= fin;
        @(negedge clk);
        while (!s_tready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_mode(input logic m);
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_random_packet(input logic udp, output int count);
        int   pick;
        int   n_addr;
        int   n_body;
        logic noisy;
        logic [7:0] b;
        logic addr;
        pick  = $urandom_range(99);
        noisy = ($urandom_range(99) < 15);
        if (udp)
            n_addr = (pick < 40) ? 8 : (pick < 75) ? 32 : $urandom_range(9);
        else
            n_addr = 0;
        if (!udp && pick < 50)
            n_body = 20;
        else if ($urandom_range(9) == 0)
            n_body = $urandom_range(200, 1);
        else
            n_body = $urandom_range(32, 1);
        count = n_addr + n_body;
        for (int i = 0; i < count; i++)
        begin
            b = 8'($urandom_range(255));
            if ($urandom_range(9) == 0)
                b = $urandom_range(1) ? 8'hFF : 8'h00;
            addr = noisy ? 1'($urandom_range(1)) : (i < n_addr);
            drive_beat(b, addr, i == count - 1);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = 1'b0;
        s_tlast        = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_mode(MODE_IPV4_HDR);
        drive_beat(8'hFF, 1'b0, 1'b1);
        drive_beat(8'h00, 1'b0, 1'b0);
        drive_beat(8'h00, 1'b0, 1'b1);
        // address flags carry no weight in header mode
        drive_beat(8'hFF, 1'b1, 1'b0);
        drive_beat(8'hFF, 1'b1, 1'b0);
        drive_beat(8'h80, 1'b0, 1'b0);
        drive_beat(8'h01, 1'b1, 1'b1);

        set_mode(MODE_UDP);
        // three address bytes, sum folds to all ones: zero given as 0xFFFF
        drive_beat(8'hFF, 1'b1, 1'b0);
        drive_beat(8'hED, 1'b1, 1'b0);
        drive_beat(8'h00, 1'b1, 1'b0);
        drive_beat(8'h00, 1'b0, 1'b1);
        for (int i = 1; i <= 5; i++)
            drive_beat(8'(i), 1'b1, 1'b0);
        drive_beat(8'h7F, 1'b0, 1'b0);
        drive_beat(8'hFF, 1'b0, 1'b1);
        drive_beat(8'h00, 1'b0, 1'b1);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct   = 86;
                    sink_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 86;
                end
                default:
                begin
                    src_idle_pct   = 37;
                    sink_stall_pct = 37;
                end
            endcase
            for (int m = 0; m < 2; m++)
            begin
                set_mode(m ? MODE_UDP : MODE_IPV4_HDR);
                sent = 0;
                while (sent < BYTES_PER_PHASE)
                begin
                    send_random_packet(m ? MODE_UDP : MODE_IPV4_HDR, n_sent);
                    sent += n_sent;
                end
            end
        end

        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* filelist.f */
src/ucs_pkg.sv
src/ucs_accum.sv
src/ucs_finish.sv
src/udp_ip_checksum_stream_unit.sv
sim/ucs_checker.sv
sim/tb_top.sv
